>>> rtl/rpa_pkg.sv
// Shared types, constants and codes for the resource pool allocator.
package rpa_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int POOL_COUNT  = 3;
    localparam int MAX_GRANTS  = 16;

    localparam int POOL_W    = 2;
    localparam int SLOT_W    = $clog2(QUEUE_DEPTH);
    localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int CNT_W     = $clog2(MAX_GRANTS + 1);
    localparam int RAM_DEPTH = POOL_COUNT * QUEUE_DEPTH;
    localparam int ADDR_W    = POOL_W + SLOT_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [POOL_W-1:0]    POOL_LIMIT = POOL_W'(POOL_COUNT);
    localparam logic [FILL_W-1:0]    FILL_MAX   = FILL_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0]     CNT_MAX    = CNT_W'(MAX_GRANTS);
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = CFG_IDX_W'(POOL_COUNT);

    localparam logic MODE_RESERVE = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        OUT_GRANTED = 2'd0,
        OUT_QUEUED  = 2'd1,
        OUT_DENIED  = 2'd2,
        OUT_REFUSED = 2'd3
    } t_outcome;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_CHECK,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic        mode;
        logic [1:0]  pool_index;
        logic [15:0] job_tag;
        logic [15:0] unit_count;
        logic [7:0]  requester_tag;
    } t_req_item;

    typedef struct packed {
        t_outcome    outcome;
        logic [15:0] granted_job;
        logic [7:0]  granted_requester;
        logic        last_result;
    } t_res_item;

    typedef struct packed {
        logic [15:0] job;
        logic [15:0] units;
        logic [7:0]  requester;
    } t_wait_entry;

    localparam int ENTRY_W = $bits(t_wait_entry);

endpackage

>>> rtl/rpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/resource_pool_allocator_fifo_unit.sv
// Resource pool allocator: per-pool counting semaphore with FIFO wait queue.
// Reserve or not-held request: the result is registered in the execute state, which waits
// while the output is stalled. Release: add units, then per granted entry a queue RAM read and
// a compare/subtract in the shared adder, at most 16 entries; a queued head that does not fit
// ends the release. No new request is accepted until the unit is idle. Output stall holds.
// Synchronous active-low reset clears capacities, free counts, heads, fills; not queue RAM.
module resource_pool_allocator_fifo_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  rpa_pkg::t_req_item              i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output rpa_pkg::t_res_item              o_out_item,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rpa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [15:0]                     i_cfg_data
);

    rpa_pkg::t_state    r_state, n_state;
    rpa_pkg::t_req_item r_req;
    rpa_pkg::t_res_item r_out, r_pend;
    logic               r_out_valid, r_pend_valid;

    logic [15:0]                 r_cap  [rpa_pkg::POOL_COUNT];
    logic [15:0]                 r_free [rpa_pkg::POOL_COUNT];
    logic [rpa_pkg::SLOT_W-1:0]  r_head [rpa_pkg::POOL_COUNT];
    logic [rpa_pkg::FILL_W-1:0]  r_fill [rpa_pkg::POOL_COUNT];
    logic [rpa_pkg::CNT_W-1:0]   r_cnt;

    logic                        in_accept, out_free, held;
    logic [rpa_pkg::POOL_W-1:0]  pool;
    logic [15:0]                 cur_free, cur_cap, alu_b;
    logic [rpa_pkg::SLOT_W-1:0]  cur_head;
    logic [rpa_pkg::FILL_W-1:0]  cur_fill;
    logic                        alu_sub;
    logic [16:0]                 alu_res;
    logic                        fits_now;

    logic                        ram_we, ram_re;
    logic [rpa_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr;
    rpa_pkg::t_wait_entry        ram_wdata, ram_rdata;
    logic                        out_load;
    rpa_pkg::t_res_item          out_next;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign pool        = r_req.pool_index;
    assign held        = r_req.pool_index < rpa_pkg::POOL_LIMIT;
    assign cur_free    = held ? r_free[pool] : 16'd0;
    assign cur_cap     = held ? r_cap[pool]  : 16'd0;
    assign cur_head    = held ? r_head[pool] : '0;
    assign cur_fill    = held ? r_fill[pool] : '0;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_cfg_ready = (r_state == rpa_pkg::ST_IDLE);

    // shared add/subtract unit: free count against request or queued units
    always_comb begin
        alu_sub = !((r_state == rpa_pkg::ST_EXEC) && (r_req.mode == rpa_pkg::MODE_RELEASE));
        alu_b   = (r_state == rpa_pkg::ST_CHECK) ? ram_rdata.units : r_req.unit_count;
        alu_res = {1'b0, cur_free} + ({1'b0, alu_b} ^ {17{alu_sub}}) + {16'd0, alu_sub};
    end

    assign fits_now = !alu_res[16];

    rpa_ram #(
        .WIDTH (rpa_pkg::ENTRY_W),
        .DEPTH (rpa_pkg::RAM_DEPTH)
    ) u_wait_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            rpa_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_state = rpa_pkg::ST_EXEC;
                end
            end
            rpa_pkg::ST_EXEC: begin
                if (held && r_req.mode == rpa_pkg::MODE_RELEASE) begin
                    n_state = rpa_pkg::ST_READ;
                end else if (out_free) begin
                    n_state = rpa_pkg::ST_IDLE;
                end
            end
            rpa_pkg::ST_READ: begin
                if (cur_fill != '0 && r_cnt < rpa_pkg::CNT_MAX) begin
                    n_state = rpa_pkg::ST_CHECK;
                end else begin
                    n_state = rpa_pkg::ST_FLUSH;
                end
            end
            rpa_pkg::ST_CHECK: begin
                if (!fits_now) begin
                    n_state = rpa_pkg::ST_FLUSH;
                end else if (!r_pend_valid || out_free) begin
                    n_state = rpa_pkg::ST_READ;
                end
            end
            rpa_pkg::ST_FLUSH: begin
                if (!r_pend_valid || out_free) begin
                    n_state = rpa_pkg::ST_IDLE;
                end
            end
            default: n_state = rpa_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_waddr  = {pool, cur_head + cur_fill[rpa_pkg::SLOT_W-1:0]};
        ram_raddr  = {pool, cur_head};
        ram_wdata  = '{job: r_req.job_tag, units: r_req.unit_count,
                       requester: r_req.requester_tag};
        out_load   = 1'b0;
        out_next   = '{outcome: rpa_pkg::OUT_GRANTED, granted_job: r_req.job_tag,
                       granted_requester: r_req.requester_tag, last_result: 1'b1};
        case (r_state)
            rpa_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            rpa_pkg::ST_EXEC: begin
                if (!held) begin
                    out_load         = out_free;
                    out_next.outcome = rpa_pkg::OUT_DENIED;
                end else if (r_req.mode == rpa_pkg::MODE_RESERVE) begin
                    out_load = out_free;
                    if (fits_now && r_req.unit_count <= cur_cap) begin
                        out_next.outcome = rpa_pkg::OUT_GRANTED;
                    end else if (cur_fill < rpa_pkg::FILL_MAX) begin
                        out_next.outcome = rpa_pkg::OUT_QUEUED;
                        ram_we           = out_free;
                    end else begin
                        out_next.outcome = rpa_pkg::OUT_REFUSED;
                    end
                end
            end
            rpa_pkg::ST_READ: begin
                ram_re = (cur_fill != '0) && (r_cnt < rpa_pkg::CNT_MAX);
            end
            rpa_pkg::ST_CHECK: begin
                out_load             = fits_now && r_pend_valid && out_free;
                out_next             = r_pend;
                out_next.last_result = 1'b0;
            end
            rpa_pkg::ST_FLUSH: begin
                out_load             = r_pend_valid && out_free;
                out_next             = r_pend;
                out_next.last_result = 1'b1;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= rpa_pkg::ST_IDLE;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
            r_cnt        <= '0;
            for (int p = 0; p < rpa_pkg::POOL_COUNT; p++) begin
                r_cap[p]  <= 16'd0;
                r_free[p] <= 16'd0;
                r_head[p] <= '0;
                r_fill[p] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready && i_cfg_index < rpa_pkg::CFG_LIMIT) begin
                r_cap[i_cfg_index[rpa_pkg::POOL_W-1:0]]  <= i_cfg_data;
                r_free[i_cfg_index[rpa_pkg::POOL_W-1:0]] <= i_cfg_data;
            end
            case (r_state)
                rpa_pkg::ST_EXEC: begin
                    r_pend_valid <= 1'b0;
                    r_cnt        <= '0;
                    if (held && r_req.mode == rpa_pkg::MODE_RELEASE) begin
                        r_free[pool] <= alu_res[16] ? 16'hFFFF : alu_res[15:0];
                    end else if (held && out_free) begin
                        if (fits_now && r_req.unit_count <= cur_cap) begin
                            r_free[pool] <= alu_res[15:0];
                        end else if (cur_fill < rpa_pkg::FILL_MAX) begin
                            r_fill[pool] <= cur_fill + 1'b1;
                        end
                    end
                end
                rpa_pkg::ST_CHECK: begin
                    if (fits_now && (!r_pend_valid || out_free)) begin
                        r_free[pool] <= alu_res[15:0];
                        r_head[pool] <= cur_head + 1'b1;
                        r_fill[pool] <= cur_fill - 1'b1;
                        r_cnt        <= r_cnt + 1'b1;
                        r_pend_valid <= 1'b1;
                    end
                end
                rpa_pkg::ST_FLUSH: begin
                    if (out_free) begin
                        r_pend_valid <= 1'b0;
                    end
                end
                default: begin
                    r_cnt <= r_cnt;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req <= i_in_item;
        end
        if (out_load) begin
            r_out <= out_next;
        end
        if (r_state == rpa_pkg::ST_CHECK && fits_now && (!r_pend_valid || out_free)) begin
            r_pend <= '{outcome: rpa_pkg::OUT_GRANTED, granted_job: ram_rdata.job,
                        granted_requester: ram_rdata.requester, last_result: 1'b0};
        end
    end

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill[0] <= rpa_pkg::FILL_MAX && r_fill[1] <= rpa_pkg::FILL_MAX &&
        r_fill[2] <= rpa_pkg::FILL_MAX)
        else $error("wait queue fill above depth");

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == rpa_pkg::ST_IDLE |-> !r_pend_valid)
        else $error("held grant left behind at idle");

    a_grant_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= rpa_pkg::CNT_MAX)
        else $error("grant count above limit");

    a_check_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == rpa_pkg::ST_CHECK |->
            $past(r_state) == rpa_pkg::ST_READ || $past(r_state) == rpa_pkg::ST_CHECK)
        else $error("compare without queue read");
`endif

endmodule

>>> test/testbench.sv
// Self-checking testbench for the resource pool allocator with per-pool FIFO wait queues.
module testbench;
    import rpa_pkg::*;

    localparam int CYCLE_LIMIT    = 600000;
    localparam int SETTLE_CYCLES  = 64;
    localparam int REPORT_LIMIT   = 10;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_REQUESTS = 33;
    localparam int REG_CAPACITY_POOL0 = 0;

    class grant_predictor;
        logic [15:0] capacity_units[POOL_COUNT];
        logic [15:0] free_units[POOL_COUNT];
        t_wait_entry waiting[POOL_COUNT][$];
        t_res_item   awaited[$];
        int          failures;
        int          requests_seen;
        int          results_seen;
        int          outcome_tally[4];

        function new();
            for (int i = 0; i < POOL_COUNT; i++) begin
                capacity_units[i] = '0;
                free_units[i] = '0;
            end
            failures = 0;
            requests_seen = 0;
            results_seen = 0;
            for (int i = 0; i < 4; i++) begin
                outcome_tally[i] = 0;
            end
        endfunction

        function void set_capacity(int idx, logic [15:0] value);
            if (idx < POOL_COUNT) begin
                capacity_units[idx] = value;
                free_units[idx] = value;
            end
        endfunction

        function void add_result(t_outcome oc, logic [15:0] job, logic [7:0] who, logic last);
            t_res_item r;
            r.outcome = oc;
            r.granted_job = job;
            r.granted_requester = who;
            r.last_result = last;
            awaited.push_back(r);
        endfunction

        function void note_request(t_req_item rq);
            int          p;
            int unsigned total;
            int          grants;
            t_wait_entry e;
            p = int'(rq.pool_index);
            requests_seen++;
            if (p >= POOL_COUNT) begin
                add_result(OUT_DENIED, rq.job_tag, rq.requester_tag, 1'b1);
                return;
            end
            if (rq.mode == MODE_RESERVE) begin
                if (free_units[p] >= rq.unit_count && rq.unit_count <= capacity_units[p]) begin
                    free_units[p] = free_units[p] - rq.unit_count;
                    add_result(OUT_GRANTED, rq.job_tag, rq.requester_tag, 1'b1);
                end else if (waiting[p].size() < QUEUE_DEPTH) begin
                    e.job = rq.job_tag;
                    e.units = rq.unit_count;
                    e.requester = rq.requester_tag;
                    waiting[p].push_back(e);
                    add_result(OUT_QUEUED, rq.job_tag, rq.requester_tag, 1'b1);
                end else begin
                    add_result(OUT_REFUSED, rq.job_tag, rq.requester_tag, 1'b1);
                end
                return;
            end
            total = 32'(free_units[p]) + 32'(rq.unit_count);
            free_units[p] = (total > 32'hFFFF) ? 16'hFFFF : 16'(total);
            grants = 0;
            while (waiting[p].size() > 0 && grants < MAX_GRANTS
                   && free_units[p] >= waiting[p][0].units) begin
                e = waiting[p].pop_front();
                free_units[p] = free_units[p] - e.units;
                add_result(OUT_GRANTED, e.job, e.requester, 1'b0);
                grants++;
            end
            if (grants > 0) begin
                awaited[awaited.size() - 1].last_result = 1'b1;
            end
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= REPORT_LIMIT) begin
                $display("MISMATCH: %s", msg);
            end
        endfunction

        function void check_result(t_res_item got);
            t_res_item want;
            results_seen++;
            if (awaited.size() == 0) begin
                flag($sformatf("result with nothing awaited: outcome %0d job %h requester %h last %0d",
                               got.outcome, got.granted_job, got.granted_requester,
                               got.last_result));
                return;
            end
            want = awaited.pop_front();
            outcome_tally[want.outcome]++;
            if (got.outcome !== want.outcome || got.granted_job !== want.granted_job
                || got.granted_requester !== want.granted_requester
                || got.last_result !== want.last_result) begin
                flag($sformatf({"expected outcome %0d job %h requester %h last %0d, ",
                                "got outcome %0d job %h requester %h last %0d"},
                               want.outcome, want.granted_job, want.granted_requester,
                               want.last_result, got.outcome, got.granted_job,
                               got.granted_requester, got.last_result));
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    t_req_item            in_item = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_res_item            out_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data = '0;

    grant_predictor sb = new();
    bit calm = 1'b0;
    bit settling = 1'b0;
    int cycles = 0;
    int config_writes = 0;
    int stall_left = 0;

    resource_pool_allocator_fifo_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid === 1'b1 && !out_stall) begin
            sb.check_result(out_item);
        end
    end

    // hold the result side in random bursts
    initial begin
        forever begin
            @(negedge i_clk);
            if (calm || settling) begin
                stall_left = 0;
                out_stall = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_stall = 1'b1;
            end else if ($urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 7) - 1;
                out_stall = 1'b1;
            end else begin
                out_stall = 1'b0;
            end
        end
    end

    task automatic send_request(input logic mode, input logic [1:0] pool,
                                input logic [15:0] job, input logic [15:0] units,
                                input logic [7:0] who);
        t_req_item rq;
        rq.mode = mode;
        rq.pool_index = pool;
        rq.job_tag = job;
        rq.unit_count = units;
        rq.requester_tag = who;
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_item = rq;
        forever begin
            @(posedge i_clk);
            if (!in_stall) break;
        end
        sb.note_request(rq);
    endtask

    task automatic idle_inputs();
        @(negedge i_clk);
        in_valid = 1'b0;
    endtask

    task automatic settle();
        settling = 1'b1;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        settling = 1'b0;
    endtask

    task automatic write_capacity(input int idx, input logic [15:0] value);
        @(negedge i_clk);
        cfg_valid = 1'b1;
        cfg_index = CFG_IDX_W'(idx);
        cfg_data = value;
        forever begin
            @(posedge i_clk);
            if (cfg_ready) break;
        end
        sb.set_capacity(idx, value);
        config_writes++;
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [15:0] pick_capacity();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom);
            default: return 16'($urandom_range(1, 48));
        endcase
    endfunction

    function automatic logic [15:0] pick_reserve_units();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom);
            default: return 16'($urandom_range(1, 24));
        endcase
    endfunction

    function automatic logic [15:0] pick_release_units();
        case ($urandom_range(0, 5))
            0: return 16'hFFFF;
            1: return 16'h0000;
            2: return 16'($urandom);
            default: return 16'($urandom_range(1, 60));
        endcase
    endfunction

    // reserve burst on one pool, then one release
    task automatic flood(input int pool, input int count, input bit tiny);
        logic [15:0] units;
        for (int i = 0; i < count; i++) begin
            units = tiny ? 16'($urandom_range(1, 3)) : pick_reserve_units();
            send_request(MODE_RESERVE, 2'(pool), 16'($urandom), units, 8'($urandom));
        end
        send_request(MODE_RELEASE, 2'(pool), 16'($urandom),
                     tiny ? 16'hFFFF : pick_release_units(), 8'($urandom));
    endtask

    task automatic send_random();
        logic       mode;
        logic [1:0] pool;
        mode = ($urandom_range(0, 3) == 0) ? MODE_RELEASE : MODE_RESERVE;
        pool = ($urandom_range(0, 15) == 0) ? POOL_LIMIT : 2'($urandom_range(0, POOL_COUNT - 1));
        send_request(mode, pool, 16'($urandom),
                     (mode == MODE_RELEASE) ? pick_release_units() : pick_reserve_units(),
                     8'($urandom));
    endtask

    task automatic run_phase(input int budget);
        int done;
        int count;
        done = 0;
        while (done < budget) begin
            if ($urandom_range(0, 3) == 0) begin
                count = $urandom_range(6, 20);
                flood($urandom_range(0, POOL_COUNT - 1), count, 1'b0);
                done += count + 1;
            end else begin
                send_random();
                done++;
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_capacity(REG_CAPACITY_POOL0, 16'd100);
        write_capacity(REG_CAPACITY_POOL0 + 1, 16'h0000);
        write_capacity(REG_CAPACITY_POOL0 + 2, 16'hFFFF);
        write_capacity(int'(CFG_LIMIT), 16'h5A5A);

        send_request(MODE_RESERVE, 2'd0, 16'h0000, 16'd40, 8'h00);
        send_request(MODE_RESERVE, 2'd0, 16'hFFFF, 16'd70, 8'hFF);
        send_request(MODE_RESERVE, 2'd0, 16'h1234, 16'd200, 8'h11);
        send_request(MODE_RESERVE, 2'd0, 16'h2345, 16'h0000, 8'h22);
        send_request(MODE_RELEASE, 2'd0, 16'h3456, 16'd10, 8'h33);
        send_request(MODE_RELEASE, 2'd0, 16'h4567, 16'h0000, 8'h44);
        send_request(MODE_RESERVE, POOL_LIMIT, 16'hA5A5, 16'd5, 8'h5A);
        send_request(MODE_RELEASE, POOL_LIMIT, 16'h5A5A, 16'hFFFF, 8'hA5);
        send_request(MODE_RESERVE, 2'd1, 16'h0101, 16'd1, 8'h01);
        send_request(MODE_RESERVE, 2'd1, 16'h0202, 16'h0000, 8'h02);
        send_request(MODE_RELEASE, 2'd1, 16'h0303, 16'hFFFF, 8'h03);
        send_request(MODE_RELEASE, 2'd2, 16'h0404, 16'd1, 8'h04);
        send_request(MODE_RESERVE, 2'd2, 16'h0505, 16'hFFFF, 8'h05);
        send_request(MODE_RELEASE, 2'd0, 16'h0606, 16'hFFFF, 8'h06);
        send_request(MODE_RESERVE, 2'd2, 16'h0707, 16'd100, 8'h07);
        send_request(MODE_RESERVE, 2'd2, 16'h0808, 16'd200, 8'h08);
        send_request(MODE_RESERVE, 2'd2, 16'h0909, 16'd300, 8'h09);
        send_request(MODE_RELEASE, 2'd2, 16'h0A0A, 16'd600, 8'h0A);

        // fill pool 1 past its queue, then drain it in one release
        flood(1, QUEUE_DEPTH + 2, 1'b1);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph > 0) begin
                idle_inputs();
                settle();
                for (int i = 0; i < POOL_COUNT; i++) begin
                    write_capacity(REG_CAPACITY_POOL0 + i, pick_capacity());
                end
                if ($urandom_range(0, 1) == 0) begin
                    write_capacity(int'(CFG_LIMIT), 16'($urandom));
                end
            end
            if (ph == RANDOM_PHASES - 1) begin
                calm = 1'b1;
            end
            run_phase(PHASE_REQUESTS);
        end

        idle_inputs();
        settle();
        $display("covered %0d requests in %0d capacity settings (%0d register writes)",
                 sb.requests_seen, RANDOM_PHASES, config_writes);
        $display("checked %0d results: %0d granted, %0d queued, %0d denied, %0d refused",
                 sb.results_seen, sb.outcome_tally[OUT_GRANTED], sb.outcome_tally[OUT_QUEUED],
                 sb.outcome_tally[OUT_DENIED], sb.outcome_tally[OUT_REFUSED]);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
